// ===== sv/gnct_pkg.sv =====
// ============================================================================
// Grid neighbour count package
// Shared widths, constants, register indexes and the structures that pass
// between the top level and the neighbourhood decision logic.
// ============================================================================
package gnct_pkg;

    // Default length of the row store, in cells.
    localparam int LINE_MAX_DEF = 256;

    // Fixed field widths.
    localparam int ROW_WIDTH_W = 9;
    localparam int LIMIT_W     = 4;
    localparam int COUNT_W     = 17;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 1;

    // The total stops growing here.
    localparam logic [COUNT_W-1:0] COUNT_CAP = 17'd65536;

    // Values after reset.
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST      = 9'd256;
    localparam logic [LIMIT_W-1:0]     NEIGHBOR_LIMIT_RST = 4'd4;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_WIDTH      = 1'b0,
        CFG_NEIGHBOR_LIMIT = 1'b1
    } t_cfg_idx;

    // Cells around the column being worked on. Suffix l2 is two columns to
    // the left of the arriving cell, l1 one column to the left, c the column
    // of the arriving cell itself.
    typedef struct packed {
        logic up_l2;
        logic up_l1;
        logic up_c;
        logic mid_l2;
        logic mid_l1;
        logic mid_c;
        logic cur_l2;
        logic cur_l1;
        logic occ;
    } t_window;

    // Where the arriving cell stands in the row and which stored rows hold data.
    typedef struct packed {
        logic col_ge1;   // column is at least one
        logic col_ge2;   // column is at least two
        logic l2_in;     // column minus two lies inside the row width
        logic l1_in;     // column minus one lies inside the row width
        logic c_in;      // column lies inside the row width
        logic row_end;   // this cell closes the row
        logic mid_ok;    // the middle row holds data
        logic up_ok;     // the upper row holds data
    } t_span;

    // Cells that count on this word.
    typedef struct packed {
        logic mid_prev;  // middle row, one column left
        logic cur_prev;  // arriving row, one column left, no row below
        logic mid_end;   // middle row, closing column
        logic cur_end;   // arriving row, closing column, no row below
    } t_verdict;

endpackage

// ===== sv/gnct_cell_if.sv =====
// ============================================================================
// Cell channel
// Carries one grid cell per word, with a valid and ready handshake.
// ============================================================================
interface gnct_cell_if;
    logic valid;
    logic ready;
    logic occupied;
    logic last_cell;

    modport source (output valid, output occupied, output last_cell, input ready);
    modport sink   (input valid, input occupied, input last_cell, output ready);
endinterface

// ===== sv/gnct_count_if.sv =====
// ============================================================================
// Count channel
// Carries the grid total, one word per grid, with a valid and ready handshake.
// ============================================================================
interface gnct_count_if;
    logic                               valid;
    logic                               ready;
    logic [gnct_pkg::COUNT_W-1:0]       accessible_count;

    modport source (output valid, output accessible_count, input ready);
    modport sink   (input valid, input accessible_count, output ready);
endinterface

// ===== sv/gnct_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module gnct_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = gnct_pkg::LINE_MAX_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/gnct_decide.sv =====
// ============================================================================
// Neighbourhood decision
// Counts occupied neighbours in the 3x3 window and decides which cells count.
// ============================================================================
module gnct_decide (
    input  gnct_pkg::t_window                i_win,
    input  gnct_pkg::t_span                  i_span,
    input  logic [gnct_pkg::LIMIT_W-1:0]     i_limit,
    output gnct_pkg::t_verdict               o_verdict
);

    logic       ul, uc, ur, ml, mc, mr, bl, bc, br;
    logic       ue_l, ue_c, me_l, me_c, be_l;
    logic [3:0] n_mid_prev, n_cur_prev, n_mid_end, n_cur_end;

    always_comb begin
        // Window for the cell one column to the left; the row width bounds it.
        ul = i_win.up_l2  & i_span.up_ok  & i_span.col_ge2 & i_span.l2_in;
        uc = i_win.up_l1  & i_span.up_ok  & i_span.l1_in;
        ur = i_win.up_c   & i_span.up_ok  & i_span.c_in;
        ml = i_win.mid_l2 & i_span.mid_ok & i_span.col_ge2 & i_span.l2_in;
        mc = i_win.mid_l1 & i_span.mid_ok & i_span.l1_in;
        mr = i_win.mid_c  & i_span.mid_ok & i_span.c_in;
        bl = i_win.cur_l2 & i_span.col_ge2;
        bc = i_win.cur_l1;
        br = i_win.occ;

        n_mid_prev = 4'(ul) + 4'(uc) + 4'(ur) + 4'(ml) + 4'(mr)
                   + 4'(bl) + 4'(bc) + 4'(br);
        n_cur_prev = 4'(ml) + 4'(mc) + 4'(mr) + 4'(bl) + 4'(br);

        // Window for the closing column: everything to its right is outside.
        ue_l = i_win.up_l1  & i_span.up_ok  & i_span.col_ge1;
        ue_c = i_win.up_c   & i_span.up_ok;
        me_l = i_win.mid_l1 & i_span.mid_ok & i_span.col_ge1;
        me_c = i_win.mid_c  & i_span.mid_ok;
        be_l = i_win.cur_l1 & i_span.col_ge1;

        n_mid_end = 4'(ue_l) + 4'(ue_c) + 4'(me_l) + 4'(be_l) + 4'(i_win.occ);
        n_cur_end = 4'(me_l) + 4'(me_c) + 4'(be_l);

        o_verdict.mid_prev = i_span.col_ge1 & mc & (n_mid_prev < i_limit);
        o_verdict.cur_prev = i_span.col_ge1 & bc & (n_cur_prev < i_limit);
        o_verdict.mid_end  = i_span.row_end & me_c & (n_mid_end < i_limit);
        o_verdict.cur_end  = i_span.row_end & i_win.occ & (n_cur_end < i_limit);
    end

endmodule

// ===== sv/grid_neighbor_count_threshold.sv =====
// ============================================================================
// Grid neighbour count with threshold
// Counts the occupied cells of a binary grid that have fewer occupied
// neighbours than a limit, and returns the total at the end of each grid.
// ============================================================================
// The block takes one cell per cycle in raster order whenever the cell channel
// is not stalled; a grid's total reaches the count channel through the input
// register and the result register once the word with last_cell is taken. The
// cell channel stalls only when a last cell arrives while the previous total is
// still waiting on the count channel, and it stays open whenever no total is
// held there. Each cell passes an input register, whose cycle also reads the
// row store, and then a single pass of window logic into the result registers.
// A cell of the row above is decided once the cell below and to its right has
// arrived; the final row is settled by a running tally that assumes no row
// follows. Rows shorter than the configured width end early on last_cell, and
// the total saturates at 65536. The row store needs no clearing pass after
// reset: each entry keeps the latest cell written at its column and the one
// before that, and two extent registers tell which of the two belongs to the
// upper row. Configuration is taken with the word it applies to, so a write may
// come in the cycle after the last accepted word.
// ============================================================================
module grid_neighbor_count_threshold #(
    parameter int LINE_MAX = gnct_pkg::LINE_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gnct_cell_if.sink                         i_cell,
    gnct_count_if.source                      o_count,
    input  logic                              i_cfg_we,
    input  logic [gnct_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gnct_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int COL_W   = $clog2(LINE_MAX);
    localparam int EW_W    = $clog2(LINE_MAX + 1);
    localparam int CMP_W   = ((EW_W > gnct_pkg::ROW_WIDTH_W) ? EW_W : gnct_pkg::ROW_WIDTH_W) + 1;
    localparam int SUM_W   = ((gnct_pkg::COUNT_W > EW_W) ? gnct_pkg::COUNT_W : EW_W) + 2;
    localparam int COUNT_W = gnct_pkg::COUNT_W;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [gnct_pkg::ROW_WIDTH_W-1:0] r_row_width;
    logic [gnct_pkg::LIMIT_W-1:0]     r_neighbor_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width      <= gnct_pkg::ROW_WIDTH_RST;
            r_neighbor_limit <= gnct_pkg::NEIGHBOR_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (gnct_pkg::t_cfg_idx'(i_cfg_idx))
                gnct_pkg::CFG_ROW_WIDTH: begin
                    r_row_width <= i_cfg_wdata[gnct_pkg::ROW_WIDTH_W-1:0];
                end
                gnct_pkg::CFG_NEIGHBOR_LIMIT: begin
                    r_neighbor_limit <= i_cfg_wdata[gnct_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Input side: effective width, column counter and row end
    // ------------------------------------------------------------------------
    logic             cell_acc;
    logic             s2_go;
    logic [CMP_W-1:0] rw_x;
    logic [CMP_W-1:0] eff_x;
    logic [EW_W-1:0]  eff_width;
    logic             row_end;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;

    // A width of zero behaves as one; one beyond the store behaves as its length.
    always_comb begin
        rw_x = CMP_W'(r_row_width);
        if (rw_x == '0) begin
            eff_x = CMP_W'(1);
        end else if (rw_x > CMP_W'(LINE_MAX)) begin
            eff_x = CMP_W'(LINE_MAX);
        end else begin
            eff_x = rw_x;
        end
        eff_width = eff_x[EW_W-1:0];
        row_end   = i_cell.last_cell | ((CMP_W'(r_col) + CMP_W'(1)) >= eff_x);
        n_col     = row_end ? '0 : r_col + COL_W'(1);
    end

    assign cell_acc = i_cell.valid & i_cell.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (cell_acc) begin
            r_col <= n_col;
        end
    end

    // ------------------------------------------------------------------------
    // Input register, filled together with the row store read
    // ------------------------------------------------------------------------
    logic                         r_s1_vld;
    logic                         r_s1_occ;
    logic                         r_s1_last;
    logic                         r_s1_end;
    logic [COL_W-1:0]             r_s1_col;
    logic [EW_W-1:0]              r_s1_w;
    logic [gnct_pkg::LIMIT_W-1:0] r_s1_lim;
    logic                         r_s1_fwd;
    logic [1:0]                   r_s1_fwd_data;
    logic [1:0]                   ram_q;
    logic [1:0]                   wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (cell_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s2_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    // When a one-cell row is followed by another row, the entry being written is
    // also the one being read, so the fresh data is carried past the store.
    always_ff @(posedge i_clk) begin
        if (cell_acc) begin
            r_s1_occ      <= i_cell.occupied;
            r_s1_last     <= i_cell.last_cell;
            r_s1_end      <= row_end;
            r_s1_col      <= r_col;
            r_s1_w        <= eff_width;
            r_s1_lim      <= r_neighbor_limit;
            r_s1_fwd      <= s2_go && (r_s1_col == r_col);
            r_s1_fwd_data <= wdata;
        end
    end

    // Each entry holds the latest cell at its column in bit 0 and the cell it
    // replaced from an earlier row in bit 1.
    gnct_ram #(
        .WIDTH (2),
        .DEPTH (LINE_MAX)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (s2_go),
        .i_waddr (r_s1_col),
        .i_wdata (wdata),
        .i_re    (cell_acc),
        .i_raddr (r_col),
        .o_rdata (ram_q)
    );

    // ------------------------------------------------------------------------
    // Window and decision
    // ------------------------------------------------------------------------
    logic [1:0]       r_rows_seen;
    logic [COL_W-1:0] r_cur_ext;
    logic             r_cur_vld;
    logic [COL_W-1:0] r_prev_ext;
    logic             r_prev_vld;
    logic [1:0]       r_recent;
    logic [1:0]       r_up_win;
    logic [1:0]       r_mid_win;

    logic [1:0]       rd;
    logic             mid_c;
    logic             up_c;
    logic             seen_cur;
    logic [COL_W-1:0] ext_after;
    logic [EW_W:0]    c_x;
    logic [EW_W:0]    w_x;

    gnct_pkg::t_window  win;
    gnct_pkg::t_span    span;
    gnct_pkg::t_verdict verdict;

    // The extent registers record how far the current and the previous row
    // reached. An entry the previous row wrote keeps the upper row's cell in
    // bit 1; an entry it did not reach holds the same cell in both rows.
    always_comb begin
        rd        = r_s1_fwd ? r_s1_fwd_data : ram_q;
        mid_c     = rd[0];
        up_c      = (r_prev_vld && (r_s1_col <= r_prev_ext)) ? rd[1] : rd[0];
        seen_cur  = r_cur_vld && (r_s1_col <= r_cur_ext);
        wdata     = {seen_cur ? rd[1] : rd[0], r_s1_occ};
        ext_after = seen_cur ? r_cur_ext : r_s1_col;

        c_x = (EW_W + 1)'(r_s1_col);
        w_x = (EW_W + 1)'(r_s1_w);

        win.up_l2  = r_up_win[1];
        win.up_l1  = r_up_win[0];
        win.up_c   = up_c;
        win.mid_l2 = r_mid_win[1];
        win.mid_l1 = r_mid_win[0];
        win.mid_c  = mid_c;
        win.cur_l2 = r_recent[1];
        win.cur_l1 = r_recent[0];
        win.occ    = r_s1_occ;

        span.col_ge1 = (r_s1_col != '0);
        span.col_ge2 = (r_s1_col > COL_W'(1));
        span.l2_in   = c_x < (w_x + (EW_W + 1)'(2));
        span.l1_in   = c_x <= w_x;
        span.c_in    = c_x < w_x;
        span.row_end = r_s1_end;
        span.mid_ok  = (r_rows_seen != 2'd0);
        span.up_ok   = r_rows_seen[1];
    end

    gnct_decide u_decide (
        .i_win     (win),
        .i_span    (span),
        .i_limit   (r_s1_lim),
        .o_verdict (verdict)
    );

    // ------------------------------------------------------------------------
    // Totals
    // ------------------------------------------------------------------------
    logic [COUNT_W-1:0] r_total;
    logic [EW_W-1:0]    r_tally;
    logic [EW_W-1:0]    n_tally;
    logic [SUM_W-1:0]   total_sum;
    logic [SUM_W-1:0]   final_sum;
    logic [COUNT_W-1:0] n_total;
    logic [COUNT_W-1:0] n_out_count;

    // All additions are non-negative, so clamping the whole sum once gives the
    // same value as saturating after each addition.
    always_comb begin
        n_tally   = r_tally + EW_W'(verdict.cur_prev) + EW_W'(verdict.cur_end);
        total_sum = SUM_W'(r_total) + SUM_W'(verdict.mid_prev) + SUM_W'(verdict.mid_end);
        final_sum = total_sum + SUM_W'(n_tally);
        n_total     = (total_sum > SUM_W'(gnct_pkg::COUNT_CAP)) ?
                      gnct_pkg::COUNT_CAP : total_sum[COUNT_W-1:0];
        n_out_count = (final_sum > SUM_W'(gnct_pkg::COUNT_CAP)) ?
                      gnct_pkg::COUNT_CAP : final_sum[COUNT_W-1:0];
    end

    // ------------------------------------------------------------------------
    // Result register and flow control
    // ------------------------------------------------------------------------
    logic               r_out_vld;
    logic [COUNT_W-1:0] r_out_count;
    logic               out_free;

    // Only a last cell has to wait for the result register; others go through.
    assign out_free      = ~r_out_vld | o_count.ready;
    assign s2_go         = r_s1_vld & (~r_s1_last | out_free);
    assign i_cell.ready  = ~r_s1_vld | s2_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_seen <= 2'd0;
            r_cur_vld   <= 1'b0;
            r_prev_vld  <= 1'b0;
            r_total     <= '0;
            r_tally     <= '0;
            r_recent    <= 2'b00;
        end else if (s2_go) begin
            r_recent <= {r_recent[0], r_s1_occ};
            if (r_s1_last) begin
                r_total     <= '0;
                r_tally     <= '0;
                r_rows_seen <= 2'd0;
            end else if (r_s1_end) begin
                r_total     <= n_total;
                r_tally     <= '0;
                r_rows_seen <= r_rows_seen[1] ? r_rows_seen : r_rows_seen + 2'd1;
            end else begin
                r_total <= n_total;
                r_tally <= n_tally;
            end
            // A row that ends without closing the grid moves the rows down.
            if (r_s1_end && !r_s1_last) begin
                r_prev_vld <= 1'b1;
                r_cur_vld  <= 1'b0;
            end else begin
                r_cur_vld  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_up_win  <= {r_up_win[0], up_c};
            r_mid_win <= {r_mid_win[0], mid_c};
            if (r_s1_end && !r_s1_last) begin
                r_prev_ext <= ext_after;
            end else begin
                r_cur_ext  <= ext_after;
            end
            if (r_s1_last) begin
                r_out_count <= n_out_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_go && r_s1_last) begin
            r_out_vld <= 1'b1;
        end else if (o_count.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_count.valid            = r_out_vld;
    assign o_count.accessible_count = r_out_count;

endmodule

// ===== sv/gnct_checker.sv =====
// ============================================================================
// Grid neighbour count checker
// Watches the top level's ports for flow and result rules.
// ============================================================================
module gnct_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_in_last,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [gnct_pkg::COUNT_W-1:0]   i_out_count
);

    // A held total keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_count))
        else $error("total changed while stalled");

    // The total never passes its ceiling.
    a_out_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_count <= gnct_pkg::COUNT_CAP))
        else $error("total above ceiling");

    // A fresh total appears only after a last cell was taken.
    a_out_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last, 2))
        else $error("total without a last cell");

    // With no total held, cells always flow.
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with the result register empty");

endmodule

bind grid_neighbor_count_threshold gnct_checker u_gnct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cell.valid),
    .i_in_ready  (i_cell.ready),
    .i_in_last   (i_cell.last_cell),
    .i_out_valid (o_count.valid),
    .i_out_ready (o_count.ready),
    .i_out_count (o_count.accessible_count)
);

// ===== dv/tb_grid_neighbor_count_threshold.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Grid neighbour count testbench
// Streams binary grids into the neighbour count block and checks every grid
// total it returns against a cycle-free predictor of the same counting rule.
// ============================================================================
module tb_grid_neighbor_count_threshold;

    localparam int CELL_SPAN_MAX = gnct_pkg::LINE_MAX_DEF;

    typedef logic [gnct_pkg::CFG_DATA_W-1:0] t_cfg_word;

    // How the two channels are paced during a phase of the run.
    typedef enum int {
        PACE_FREE,
        PACE_SENDER_GAPS,
        PACE_SINK_STALLS,
        PACE_BOTH
    } t_pace;

    // ------------------------------------------------------------------------
    // Predictor and scoreboard. It keeps its own copy of the row stores, the
    // column and row counters, the running totals and the two registers, and
    // works out the grid total whenever a word carrying last_cell is taken.
    // ------------------------------------------------------------------------
    class grid_tally_board;
        bit [CELL_SPAN_MAX-1:0]               upper_row;
        bit [CELL_SPAN_MAX-1:0]               middle_row;
        bit [CELL_SPAN_MAX-1:0]               arriving_row;
        bit [1:0]                             recent;     // bit 0 is one column left, bit 1 two
        int                                   column;
        int                                   rows_held;  // stops at two
        int unsigned                          total;
        int unsigned                          row_tally;
        logic [gnct_pkg::ROW_WIDTH_W-1:0]     row_width;
        logic [gnct_pkg::LIMIT_W-1:0]         neighbor_limit;
        logic [gnct_pkg::COUNT_W-1:0]         awaited_totals[$];
        int unsigned                          mismatches;

        function new();
            upper_row      = '0;
            middle_row     = '0;
            arriving_row   = '0;
            recent         = '0;
            column         = 0;
            rows_held      = 0;
            total          = 0;
            row_tally      = 0;
            row_width      = gnct_pkg::ROW_WIDTH_RST;
            neighbor_limit = gnct_pkg::NEIGHBOR_LIMIT_RST;
            mismatches     = 0;
        endfunction

        function void set_register(gnct_pkg::t_cfg_idx idx, t_cfg_word value);
            case (idx)
                gnct_pkg::CFG_ROW_WIDTH: begin
                    row_width = value;
                end
                gnct_pkg::CFG_NEIGHBOR_LIMIT: begin
                    neighbor_limit = value[gnct_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        // Width in force: zero behaves as one, anything past the store as its length.
        function int span();
            if (row_width == '0)
                return 1;
            if (int'(row_width) > CELL_SPAN_MAX)
                return CELL_SPAN_MAX;
            return int'(row_width);
        endfunction

        function int unsigned cell_at(bit [CELL_SPAN_MAX-1:0] row, bit ok, int idx, int lim);
            if (!ok || idx < 0 || idx >= lim || idx >= CELL_SPAN_MAX)
                return 0;
            return 32'(row[idx]);
        endfunction

        // Middle-row cell m, with b0..b2 the row below at m-1, m and m+1.
        function int unsigned judge_middle(int m, int lim, bit b0, bit b1, bit b2);
            bit          mid_ok;
            bit          up_ok;
            int unsigned n;
            mid_ok = rows_held >= 1;
            up_ok  = rows_held >= 2;
            if (cell_at(middle_row, mid_ok, m, lim) == 0)
                return 0;
            n = cell_at(upper_row, up_ok, m - 1, lim) + cell_at(upper_row, up_ok, m, lim)
              + cell_at(upper_row, up_ok, m + 1, lim)
              + cell_at(middle_row, mid_ok, m - 1, lim)
              + cell_at(middle_row, mid_ok, m + 1, lim)
              + 32'(b0) + 32'(b1) + 32'(b2);
            return (n < 32'(neighbor_limit)) ? 1 : 0;
        endfunction

        // Arriving-row cell m on the assumption that no row follows it.
        function int unsigned judge_arriving(int m, int lim, bit l, bit c, bit r);
            bit          mid_ok;
            int unsigned n;
            mid_ok = rows_held >= 1;
            if (!c)
                return 0;
            n = cell_at(middle_row, mid_ok, m - 1, lim) + cell_at(middle_row, mid_ok, m, lim)
              + cell_at(middle_row, mid_ok, m + 1, lim) + 32'(l) + 32'(r);
            return (n < 32'(neighbor_limit)) ? 1 : 0;
        endfunction

        function void bump(int unsigned v);
            total = total + v;
            if (total > 32'(gnct_pkg::COUNT_CAP))
                total = 32'(gnct_pkg::COUNT_CAP);
        endfunction

        function void take_cell(bit occ, bit last);
            int w;
            int c;
            bit one_left;
            bit two_left;
            bit row_done;
            w        = span();
            c        = column;
            one_left = recent[0];
            two_left = recent[1];
            row_done = last || (c + 1 >= w);
            arriving_row[c] = occ;
            if (c >= 1) begin
                bump(judge_middle(c - 1, w, two_left, one_left, occ));
                row_tally += judge_arriving(c - 1, w, two_left, one_left, occ);
            end
            if (row_done) begin
                bump(judge_middle(c, c + 1, one_left, occ, 1'b0));
                row_tally += judge_arriving(c, c + 1, one_left, occ, 1'b0);
            end
            if (last) begin
                bump(row_tally);
                awaited_totals.push_back(total[gnct_pkg::COUNT_W-1:0]);
                total     = 0;
                row_tally = 0;
                rows_held = 0;
                column    = 0;
                recent    = '0;
            end else if (row_done) begin
                upper_row  = middle_row;
                middle_row = arriving_row;
                if (rows_held < 2)
                    rows_held++;
                row_tally = 0;
                column    = 0;
                recent    = '0;
            end else begin
                column = c + 1;
                recent = {one_left, occ};
            end
        endfunction

        function void flag(string why);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR at %0t: %s", $realtime, why);
        endfunction

        function void check_total(logic [gnct_pkg::COUNT_W-1:0] seen);
            logic [gnct_pkg::COUNT_W-1:0] want;
            if (awaited_totals.size() == 0) begin
                flag($sformatf("total %0d arrived with no grid awaiting it", seen));
            end else begin
                want = awaited_totals.pop_front();
                if (seen !== want)
                    flag($sformatf("accessible_count expected %0d, got %0d", want, seen));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block itself.
    // ------------------------------------------------------------------------
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [gnct_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    t_cfg_word                       i_cfg_wdata;

    gnct_cell_if  cell_ch ();
    gnct_count_if count_ch ();

    grid_neighbor_count_threshold DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cell      (cell_ch),
        .o_count     (count_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    grid_tally_board board = new();

    // Chance, in percent, that the sender holds back a cycle or the receiver
    // refuses a word. Both are changed from one phase to the next.
    int unsigned sender_idle_pct = 0;
    int unsigned sink_stall_pct  = 0;
    int unsigned cells_sent      = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A ceiling on the run that stays generous even with every cell closing a
    // grid of its own and both sides stalling.
    initial begin
        #(2_000_000);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiving side. Every total taken off the count channel is checked
    // against the oldest grid still waiting; ready is redrawn every cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && count_ch.valid === 1'b1 && count_ch.ready)
            board.check_total(count_ch.accessible_count);
        count_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Sending side.
    // ------------------------------------------------------------------------

    // Offers one cell and waits for the block to take it. Valid stays high
    // from one word to the next unless a gap is drawn, so it is never lowered
    // and raised within the same edge.
    task automatic send_cell(bit occ, bit last);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            cell_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_ch.valid     <= 1'b1;
        cell_ch.occupied  <= occ;
        cell_ch.last_cell <= last;
        @(posedge i_clk);
        while (cell_ch.ready !== 1'b1)
            @(posedge i_clk);
        board.take_cell(occ, last);
        cells_sent++;
    endtask

    // Sends one grid: every row but the last is exactly as wide as the width
    // in force, so that the block ends it by width; the last row may stop
    // early on last_cell. Density is the chance in percent of an occupied cell.
    task automatic send_grid(int rows, int tail, int unsigned density);
        int w;
        int len;
        w = board.span();
        for (int r = 0; r < rows; r++) begin
            len = (r == rows - 1) ? tail : w;
            for (int c = 0; c < len; c++)
                send_cell($urandom_range(0, 99) < density, (r == rows - 1) && (c == len - 1));
        end
    endtask

    // Takes the input idle, waits until every grid total has come back, then
    // lets the pipeline drain before anything is reconfigured.
    task automatic settle();
        cell_ch.valid <= 1'b0;
        while (board.awaited_totals.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes both registers back to back, only once the block is idle.
    task automatic apply_settings(t_cfg_word width_word, t_cfg_word limit_word);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= gnct_pkg::CFG_ROW_WIDTH;
        i_cfg_wdata <= width_word;
        @(posedge i_clk);
        board.set_register(gnct_pkg::CFG_ROW_WIDTH, width_word);
        i_cfg_idx   <= gnct_pkg::CFG_NEIGHBOR_LIMIT;
        i_cfg_wdata <= limit_word;
        @(posedge i_clk);
        board.set_register(gnct_pkg::CFG_NEIGHBOR_LIMIT, limit_word);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_pace(t_pace pace);
        case (pace)
            PACE_FREE: begin
                sender_idle_pct = 0;
                sink_stall_pct  = 0;
            end
            PACE_SENDER_GAPS: begin
                sender_idle_pct = 64;
                sink_stall_pct  = 0;
            end
            PACE_SINK_STALLS: begin
                sender_idle_pct = 0;
                sink_stall_pct  = 64;
            end
            default: begin
                sender_idle_pct = 19;
                sink_stall_pct  = 19;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        int          phase;
        int          w;
        int          grids;
        int          rows;
        int          tail;
        int unsigned density;
        t_cfg_word   width_word;

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= gnct_pkg::CFG_ROW_WIDTH;
        i_cfg_wdata        <= '0;
        cell_ch.valid      <= 1'b0;
        cell_ch.occupied   <= 1'b0;
        cell_ch.last_cell  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed grids, all at full rate. Under the reset settings: a
        // single occupied cell, then a single empty one, each a whole grid.
        set_pace(PACE_FREE);
        send_grid(1, 1, 100);
        send_grid(1, 1, 0);

        // A full three by three block: the four corners have three
        // neighbours and count, the rest have five or more and do not.
        // Then a grid whose second row is cut short after two cells.
        apply_settings(9'd3, 9'd4);
        send_grid(3, 3, 100);
        send_grid(2, 2, 100);

        // A width of zero behaves as one, and a limit above nine counts
        // every occupied cell.
        apply_settings(9'd0, 9'd15);
        send_grid(3, 1, 100);

        // A width past the store behaves as the store's length; a limit of
        // zero counts nothing. The grid ends two cells into its only row.
        apply_settings(9'd300, 9'd0);
        send_grid(1, 2, 100);

        // Random phases. Each one picks a pacing and fresh settings, and then
        // sends a few grids; most are small, a handful span the whole store.
        phase = 0;
        while (cells_sent < 900) begin
            case ($urandom_range(0, 31))
                0:       width_word = 9'd0;
                1:       width_word = 9'd1;
                2:       width_word = 9'd256;
                3:       width_word = t_cfg_word'($urandom_range(257, 511));
                4:       width_word = 9'd2;
                5:       width_word = t_cfg_word'($urandom_range(65, 255));
                6, 7, 8: width_word = t_cfg_word'($urandom_range(17, 64));
                default: width_word = t_cfg_word'($urandom_range(1, 16));
            endcase
            // The limit field takes the low four bits; the rest of the word
            // is random so that every data bit is exercised.
            apply_settings(width_word, t_cfg_word'($urandom_range(0, 511)));
            set_pace(t_pace'(phase % 4));
            w     = board.span();
            grids = (w > 64) ? 1 : $urandom_range(1, 4);
            repeat (grids) begin
                if (w > 64)
                    rows = $urandom_range(1, 2);
                else if (w > 16)
                    rows = $urandom_range(1, 4);
                else
                    rows = $urandom_range(1, 6);
                // Half of the grids draw a random length for their last row; the rest fill it.
                tail = $urandom_range(0, 1) ? w : $urandom_range(1, w);
                case ($urandom_range(0, 3))
                    0:       density = 20;
                    1:       density = 50;
                    2:       density = 80;
                    default: density = 95;
                endcase
                send_grid(rows, tail, density);
            end
            phase++;
        end

        // A total that never arrives keeps this waiting until the time
        // ceiling above ends the run as a failure.
        settle();
        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/gnct_pkg.sv
sv/gnct_cell_if.sv
sv/gnct_count_if.sv
sv/gnct_ram.sv
sv/gnct_decide.sv
sv/grid_neighbor_count_threshold.sv
sv/gnct_checker.sv
dv/tb_grid_neighbor_count_threshold.sv
